@@ rtl/core/tt_pkg.sv @@
// Package of types and constants shared by the timeout table modules.
`default_nettype none
package tt_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int DELAY_BITS = 16;
  localparam int TIME_BITS  = 32;

  // Port field widths.
  localparam int DELAY_W = 16;
  localparam int KEY_W   = 16;

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    KIND_ARMED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ARM  = 2'd1,
    ST_SCAN = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic accept;     // latch the incoming item
    logic tick;       // advance the time and restart the scan
    logic arm_emit;   // store the armed entry and post its result
    logic scan_step;  // examine one entry
    logic finish;     // post the final result of a tick
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic full;
    logic scan_end;
    logic cur_expired;
    logic held_valid;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/core/timeout_table_core.sv @@
// Top level of the timeout table: controller plus datapath.
//
// Input stream: in_tuser is the mode (0 tick, 1 arm), in_tdata carries delay and key.
// An arm stores key with expiry = time + delay at the end of the table, or is rejected
// when all entries are in use; either way one result follows. A tick advances the
// 32-bit time by one and reports every expired key in arrival order while compacting
// the table; a tick with no expiry gives one "none" result. out_tlast marks the
// final result of each input transaction; out_tuser gives the result kind.
// One item is in flight at a time: in_tready is high only while the block is idle.
// An arm's result enters the output register from the ARM state, which waits for a free
// output slot; the block then returns to idle before the next transaction is accepted.
// A tick's scan reads one entry per cycle through a single registered table port,
// unless it is waiting on a busy output register.
// The result register holds its transaction while out_tready is low; the scan then
// waits on any further expiry until the register frees.
// Synchronous reset clears the time, the entry count and all valid flags; table
// contents are not cleared and need no clearing pass.
`default_nettype none
module timeout_table_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] delay, [31:16] key
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] key_out
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast
);
  import tt_pkg::*;

  cmd_t    cmd;
  status_t sts;
  kind_t   out_kind;

  tt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_delay  (in_tdata[DELAY_W-1:0]),
    .in_key    (in_tdata[DELAY_W+KEY_W-1:DELAY_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_key   (out_tdata),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_kind;

endmodule
`default_nettype wire

@@ rtl/core/tt_ctrl.sv @@
// Controller state machine of the timeout table.
`default_nettype none
module tt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire logic           in_mode,
  output logic                in_tready,
  input  wire tt_pkg::status_t sts,
  output tt_pkg::cmd_t        cmd
);
  import tt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_mode) begin
            state_nxt = ST_ARM;
          end else begin
            cmd.tick  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_ARM: begin
        if (sts.slot_free) begin
          cmd.arm_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ST_DONE;
        end else if (!(sts.cur_expired && sts.held_valid && !sts.slot_free)) begin
          // An expiry pushes out the held key, which needs a free output slot.
          cmd.scan_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.arm_emit, cmd.scan_step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_tick_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |=> state_r == ST_SCAN)
    else $error("tick did not start a scan");

  a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> $past(state_r) == ST_SCAN || $past(state_r) == ST_DONE)
    else $error("final tick result without a scan");

endmodule
`default_nettype wire

@@ rtl/core/tt_dp.sv @@
// Datapath of the timeout table: time counter, entry table, scan and output register.
`default_nettype none
module tt_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tt_pkg::DELAY_W-1:0]  in_delay,
  input  wire logic [tt_pkg::KEY_W-1:0]    in_key,
  input  wire tt_pkg::cmd_t                cmd,
  output tt_pkg::status_t                  sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tt_pkg::kind_t                    out_kind,
  output logic [tt_pkg::KEY_W-1:0]         out_key,
  output logic                             out_last
);
  import tt_pkg::*;

  logic [TIME_BITS-1:0]  time_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [CNT_BITS-1:0]   rd_r;
  logic [CNT_BITS-1:0]   wr_r;
  logic                  held_valid_r;
  logic [KEY_BITS-1:0]   held_key_r;
  logic [DELAY_BITS-1:0] delay_r;
  logic [KEY_BITS-1:0]   key_r;

  logic [TIME_BITS-1:0]  exp_mem_r [ENTRIES];
  logic [KEY_BITS-1:0]   key_mem_r [ENTRIES];

  logic                  out_valid_r;
  kind_t                 out_kind_r;
  logic [KEY_W-1:0]      out_key_r;
  logic                  out_last_r;

  logic                  out_valid_nxt;
  kind_t                 out_kind_nxt;
  logic [KEY_W-1:0]      out_key_nxt;
  logic                  out_last_nxt;

  logic [TIME_BITS-1:0]  cur_exp_r;
  logic [KEY_BITS-1:0]   cur_key_r;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [TIME_BITS-1:0]  diff;
  logic                  load_out;

  // The table is read ahead, at the scan position of the next cycle.
  always_comb begin
    priority if (cmd.tick) begin
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_addr = rd_r[IDX_BITS-1:0] + IDX_BITS'(1);
    end else begin
      rd_addr = rd_r[IDX_BITS-1:0];
    end
  end

  // Wrap-safe test: expired when the distance from expiry to now is below half the range.
  assign diff    = time_r - cur_exp_r;

  assign sts.slot_free   = !out_valid_r || out_ready;
  assign sts.full        = (count_r == CNT_BITS'(ENTRIES));
  assign sts.scan_end    = (rd_r == count_r);
  assign sts.cur_expired = !diff[TIME_BITS-1];
  assign sts.held_valid  = held_valid_r;

  assign load_out = cmd.arm_emit || cmd.finish ||
                    (cmd.scan_step && sts.cur_expired && held_valid_r);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    priority if (cmd.arm_emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (sts.full) begin
        out_kind_nxt = KIND_FULL;
        out_key_nxt  = '0;
      end else begin
        out_kind_nxt = KIND_ARMED;
        out_key_nxt  = KEY_W'(key_r);
      end
    end else if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (held_valid_r) begin
        out_kind_nxt = KIND_EXPIRED;
        out_key_nxt  = KEY_W'(held_key_r);
      end else begin
        out_kind_nxt = KIND_NONE;
        out_key_nxt  = '0;
      end
    end else if (load_out) begin
      // A newer expiry shows the held key was not the last one.
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      out_kind_nxt  = KIND_EXPIRED;
      out_key_nxt   = KEY_W'(held_key_r);
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      time_r       <= '0;
      count_r      <= '0;
      rd_r         <= '0;
      wr_r         <= '0;
      held_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.tick) begin
        time_r       <= time_r + TIME_BITS'(1);
        rd_r         <= '0;
        wr_r         <= '0;
        held_valid_r <= 1'b0;
      end
      if (cmd.arm_emit && !sts.full) begin
        count_r <= count_r + CNT_BITS'(1);
      end
      if (cmd.scan_step) begin
        rd_r <= rd_r + CNT_BITS'(1);
        if (sts.cur_expired) begin
          held_valid_r <= 1'b1;
        end else begin
          wr_r <= wr_r + CNT_BITS'(1);
        end
      end
      if (cmd.finish) begin
        count_r      <= wr_r;
        held_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.accept) begin
      delay_r <= in_delay[DELAY_BITS-1:0];
      key_r   <= in_key[KEY_BITS-1:0];
    end
    if (cmd.scan_step && sts.cur_expired) begin
      held_key_r <= cur_key_r;
    end
  end

  // Table writes: arming appends at the count, the scan compacts survivors in place.
  // The compaction write stays at or behind the scan position, so it never overwrites an entry still to be read.
  always_ff @(posedge clk) begin
    cur_exp_r <= exp_mem_r[rd_addr];
    cur_key_r <= key_mem_r[rd_addr];
    if (cmd.arm_emit && !sts.full) begin
      exp_mem_r[count_r[IDX_BITS-1:0]] <= time_r + TIME_BITS'(delay_r);
      key_mem_r[count_r[IDX_BITS-1:0]] <= key_r;
    end else if (cmd.scan_step && !sts.cur_expired) begin
      exp_mem_r[wr_r[IDX_BITS-1:0]] <= cur_exp_r;
      key_mem_r[wr_r[IDX_BITS-1:0]] <= cur_key_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_key   = out_key_r;
  assign out_last  = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(ENTRIES))
    else $error("entry count beyond table size");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= rd_r)
    else $error("compaction write overtook the scan");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> sts.slot_free)
    else $error("output register overwritten while stalled");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !held_valid_r && out_valid_r && out_last_r)
    else $error("tick did not close with a last result");

endmodule
`default_nettype wire
